// ===== rtl/duml_frame_encoder_defines.svh =====
// Assertion macros for the frame encoder RTL.
`ifndef DUML_FRAME_ENCODER_DEFINES_SVH
`define DUML_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame encoder check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define DFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame encoder check failed");
`else
`define DFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DFE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/dfe_pkg.sv =====
// Types, constants and CRC step functions of the frame encoder.
package dfe_pkg;

    // Field widths.
    localparam int LEN_W  = 10;

    // Command codes.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_SEQ_ERR  = 2'd2;

    // Frame format.
    localparam logic [7:0]       MAGIC        = 8'h55;
    localparam logic [7:0]       VERSION_BITS = 8'h04;
    localparam logic [7:0]       CRC8_SEED    = 8'h77;
    localparam logic [7:0]       CRC8_POLY    = 8'h8C;
    localparam logic [15:0]      CRC16_SEED   = 16'h3692;
    localparam logic [15:0]      CRC16_POLY   = 16'h8408;
    localparam logic [LEN_W-1:0] OVERHEAD     = LEN_W'(13);
    localparam logic [LEN_W-1:0] MAX_PAYLOAD  = LEN_W'(1023 - 13);

    // Header has eleven bytes; an empty frame adds two CRC bytes.
    localparam int HDR_LEN   = 11;
    localparam int BEATS_MAX = HDR_LEN + 2;
    localparam int IDX_W     = $clog2(BEATS_MAX);

    // Header byte positions.
    localparam logic [IDX_W-1:0] H_MAGIC = IDX_W'(0);
    localparam logic [IDX_W-1:0] H_LEN_L = IDX_W'(1);
    localparam logic [IDX_W-1:0] H_LEN_H = IDX_W'(2);
    localparam logic [IDX_W-1:0] H_CRC8  = IDX_W'(3);
    localparam logic [IDX_W-1:0] H_SEND  = IDX_W'(4);
    localparam logic [IDX_W-1:0] H_RECV  = IDX_W'(5);
    localparam logic [IDX_W-1:0] H_SEQ_L = IDX_W'(6);
    localparam logic [IDX_W-1:0] H_SEQ_H = IDX_W'(7);
    localparam logic [IDX_W-1:0] H_TYPE  = IDX_W'(8);
    localparam logic [IDX_W-1:0] H_SET   = IDX_W'(9);
    localparam logic [IDX_W-1:0] H_ID    = IDX_W'(10);

    // One input item.
    typedef struct packed {
        logic             cmd;
        logic [7:0]       sender;
        logic [7:0]       receiver;
        logic [15:0]      seq_num;
        logic [7:0]       cmd_type;
        logic [7:0]       cmd_set;
        logic [7:0]       cmd_id;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       data_byte;
    } t_in_item;

    // One wire byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } t_beat;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic busy;
        logic frame_open;
    } t_ctrl_status;

    // Reflected CRC-8, one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] v;
        v = c ^ d;
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC8_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Reflected CRC-16, one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] v;
        v = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC16_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== rtl/dfe_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface dfe_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/dfe_frame_ctrl.sv =====
// Frame sequencer: holds one input item and emits its wire bytes one per cycle while the output side is ready.
module dfe_frame_ctrl
    import dfe_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dfe_stream_if.sink    i_item,
    output logic          o_beat_valid,
    input  logic          i_beat_ready,
    output t_beat         o_beat,
    output t_ctrl_status  o_stat
);

    logic             r_busy;
    t_in_item         r_item;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_crc16;
    logic [7:0]       r_crc8;
    logic [LEN_W-1:0] r_left;
    logic             r_open;

    logic             is_start;
    logic             err_seq;
    logic             err_long;
    logic             crc_lo;
    logic             crc_hi;
    logic             is_data;
    logic             item_end;
    logic             fire;
    logic             take;
    logic [LEN_W-1:0] total;
    logic [7:0]       hdr_byte;
    logic [7:0]       data_val;
    t_beat            beat;

    // Classify the held item against the frame state.
    always_comb begin
        is_start = (r_item.cmd == CMD_START);
        err_seq  = (is_start == r_open);
        err_long = is_start && !r_open && (r_item.payload_len > MAX_PAYLOAD);
        total    = r_item.payload_len + OVERHEAD;
        crc_lo   = is_start ? (r_idx == IDX_W'(HDR_LEN))     : (r_idx == IDX_W'(1));
        crc_hi   = is_start ? (r_idx == IDX_W'(HDR_LEN + 1)) : (r_idx == IDX_W'(2));
    end

    // Header byte for the current position.
    always_comb begin
        case (r_idx)
            H_MAGIC: hdr_byte = MAGIC;
            H_LEN_L: hdr_byte = total[7:0];
            H_LEN_H: hdr_byte = {6'b0, total[LEN_W-1:8]} | VERSION_BITS;
            H_CRC8:  hdr_byte = r_crc8;
            H_SEND:  hdr_byte = r_item.sender;
            H_RECV:  hdr_byte = r_item.receiver;
            H_SEQ_L: hdr_byte = r_item.seq_num[7:0];
            H_SEQ_H: hdr_byte = r_item.seq_num[15:8];
            H_TYPE:  hdr_byte = r_item.cmd_type;
            H_SET:   hdr_byte = r_item.cmd_set;
            H_ID:    hdr_byte = r_item.cmd_id;
            default: hdr_byte = 8'h00;
        endcase
    end

    // Build the beat and decide whether it closes the item.
    always_comb begin
        data_val      = is_start ? hdr_byte : r_item.data_byte;
        beat.out_byte = 8'h00;
        beat.last     = 1'b0;
        beat.status   = ST_OK;
        is_data       = 1'b0;
        item_end      = 1'b0;
        if (err_seq) begin
            beat.status = ST_SEQ_ERR;
            item_end    = 1'b1;
        end else if (err_long) begin
            beat.status = ST_TOO_LONG;
            item_end    = 1'b1;
        end else if (crc_lo) begin
            beat.out_byte = r_crc16[7:0];
        end else if (crc_hi) begin
            beat.out_byte = r_crc16[15:8];
            beat.last     = 1'b1;
            item_end      = 1'b1;
        end else begin
            beat.out_byte = data_val;
            is_data       = 1'b1;
            if (is_start) begin
                item_end = (r_idx == IDX_W'(HDR_LEN - 1)) && (r_item.payload_len != '0);
            end else begin
                item_end = (r_left != LEN_W'(1));
            end
        end
    end

    // Handshakes: a new item enters as the last beat of the held one leaves.
    assign fire          = r_busy && i_beat_ready;
    assign i_item.ready  = !r_busy || (fire && item_end);
    assign take          = i_item.valid && i_item.ready;
    assign o_beat_valid  = r_busy;
    assign o_beat        = beat;
    assign o_stat        = '{busy: r_busy, frame_open: r_open};

    // Item register, beat counter and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_crc16 <= CRC16_SEED;
            r_left  <= '0;
            r_open  <= 1'b0;
        end else begin
            // A new item restarts the beat counter; otherwise a sent beat advances it.
            if (take) begin
                r_item <= i_item.payload;
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (fire) begin
                r_idx <= r_idx + IDX_W'(1);
                if (item_end) begin
                    r_busy <= 1'b0;
                end
            end
            if (fire) begin
                if (is_data) begin
                    r_crc16 <= crc16_byte((is_start && r_idx == H_MAGIC) ? CRC16_SEED : r_crc16,
                                          beat.out_byte);
                    if (is_start) begin
                        r_crc8 <= crc8_byte((r_idx == H_MAGIC) ? CRC8_SEED : r_crc8,
                                            beat.out_byte);
                        if (r_idx == IDX_W'(HDR_LEN - 1) && r_item.payload_len != '0) begin
                            r_open <= 1'b1;
                            r_left <= r_item.payload_len;
                        end
                    end else begin
                        r_left <= r_left - LEN_W'(1);
                    end
                end else if (crc_hi && !err_seq && !err_long) begin
                    r_crc16 <= CRC16_SEED;
                    r_left  <= '0;
                    r_open  <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/dfe_out_skid.sv =====
// Output register with a skid entry, so the sequencer never waits on a combinational ready.
module dfe_out_skid
    import dfe_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_beat_valid,
    output logic          o_beat_ready,
    input  t_beat         i_beat,
    dfe_stream_if.source  o_result
);

    logic  r_out_valid;
    t_beat r_out;
    logic  r_skid_valid;
    t_beat r_skid;
    logic  up_fire;
    logic  dn_free;

    assign o_beat_ready     = !r_skid_valid;
    assign up_fire          = i_beat_valid && !r_skid_valid;
    assign dn_free          = !r_out_valid || o_result.ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Refill the output register from the skid entry first, else from upstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (dn_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= up_fire;
                r_out       <= i_beat;
            end
        end else if (up_fire) begin
            r_skid       <= i_beat;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// ===== rtl/duml_frame_encoder.sv =====
// Framed packet encoder. Payload items pass one byte per cycle, so a payload beat is
// accepted every cycle while the output is taken. A start item holds the input while
// the header goes out (and the CRC-16 too when its payload length is zero), and the last
// payload item holds it while the CRC-16 follows; a rejected or dropped item sends only
// a status beat. The single output byte lane carries one wire byte per cycle while the
// output is taken. The first byte of an item passes through the item register and then
// the output register before it appears at the output.
`include "duml_frame_encoder_defines.svh"

module duml_frame_encoder
    import dfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dfe_stream_if.sink   i_item,
    dfe_stream_if.source o_result
);

    logic         beat_valid;
    logic         beat_ready;
    t_beat        beat;
    t_ctrl_status stat;
    logic         err_beat;
    logic         last_sent;

    // Byte sequencer.
    dfe_frame_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_beat_valid (beat_valid),
        .i_beat_ready (beat_ready),
        .o_beat       (beat),
        .o_stat       (stat)
    );

    // Output register stage.
    dfe_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .o_beat_ready (beat_ready),
        .i_beat       (beat),
        .o_result     (o_result)
    );

    // Beat conditions watched by the checks below.
    assign err_beat  = beat_valid && (beat.status != ST_OK);
    assign last_sent = beat_valid && beat_ready && beat.last;

    // Rejected or dropped items carry a zero byte and never end a frame.
    `DFE_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, err_beat, beat.out_byte == 8'h00 && !beat.last)
    // The closing CRC byte leaves the frame shut.
    `DFE_ASSERT_NXT(a_last_closes, i_clk, i_rst_n, last_sent, !stat.frame_open)
    // An idle sequencer always takes input.
    `DFE_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, !stat.busy, i_item.ready)

endmodule

// ===== dv/duml_frame_encoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the framed packet encoder: random stimulus, byte-level predictor.
module duml_frame_encoder_test;
    import dfe_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dfe_stream_if #(.t_payload(t_in_item)) item_if ();
    dfe_stream_if #(.t_payload(t_beat))    beat_if ();

    duml_frame_encoder i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (beat_if)
    );

    // Stimulus waiting to be offered, and wire bytes the encoder still owes us.
    t_in_item pending_items[$];
    t_beat    wire_bytes_q[$];

    int unsigned mismatches = 0;
    int unsigned beats_seen = 0;
    logic        item_taken = 1'b0;

    // Predictor state: running CRC-16, payload bytes still due, frame open flag.
    logic [15:0]      run_crc   = CRC16_SEED;
    logic [LEN_W-1:0] bytes_due = '0;
    logic             in_frame  = 1'b0;

    // Idle control for both sides of the encoder.
    int unsigned src_gap = 0;
    int unsigned src_tick = 0;
    logic        src_steady = 1'b0;
    int unsigned snk_gap = 0;
    int unsigned snk_tick = 0;
    logic        snk_steady = 1'b0;
    int unsigned stall_left = 0;
    logic        hold_done = 1'b0;

    // Clock with a 12 ns period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        beat_if.ready   = 1'b0;
    end

    // Reflected CRC-8, fed one data bit at a time.
    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int b = 0; b < 8; b++) begin
            fb = r[0] ^ d[b];
            r  = r >> 1;
            if (fb) r = r ^ CRC8_POLY;
        end
        return r;
    endfunction

    // Reflected CRC-16, fed one data bit at a time.
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int b = 0; b < 8; b++) begin
            fb = r[0] ^ d[b];
            r  = r >> 1;
            if (fb) r = r ^ CRC16_POLY;
        end
        return r;
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic lst,
                                      input logic [1:0] st);
        t_beat e;
        e.out_byte = b;
        e.last     = lst;
        e.status   = st;
        wire_bytes_q.insert(wire_bytes_q.size(), e);
    endfunction

    // A frame byte goes on the wire and into the running CRC.
    function automatic void emit_byte(input logic [7:0] b);
        run_crc = crc16_step(run_crc, b);
        push_beat(b, 1'b0, ST_OK);
    endfunction

    // Append the CRC-16, low byte first, and close the frame.
    function automatic void close_frame();
        push_beat(run_crc[7:0], 1'b0, ST_OK);
        push_beat(run_crc[15:8], 1'b1, ST_OK);
        run_crc   = CRC16_SEED;
        bytes_due = '0;
        in_frame  = 1'b0;
    endfunction

    // Work out the wire bytes that one accepted item produces.
    function automatic void encode_item(input t_in_item it);
        logic [7:0]       hdr[HDR_LEN];
        logic [LEN_W-1:0] total;
        logic [7:0]       c8;
        if (it.cmd == CMD_START) begin
            if (in_frame) begin
                push_beat(8'h00, 1'b0, ST_SEQ_ERR);
            end else if (it.payload_len > MAX_PAYLOAD) begin
                push_beat(8'h00, 1'b0, ST_TOO_LONG);
            end else begin
                total  = it.payload_len + OVERHEAD;
                hdr[0] = MAGIC;
                hdr[1] = total[7:0];
                hdr[2] = {6'b0, total[9:8]} | VERSION_BITS;
                c8 = CRC8_SEED;
                for (int i = 0; i < 3; i++) c8 = crc8_step(c8, hdr[i]);
                hdr[3]  = c8;
                hdr[4]  = it.sender;
                hdr[5]  = it.receiver;
                hdr[6]  = it.seq_num[7:0];
                hdr[7]  = it.seq_num[15:8];
                hdr[8]  = it.cmd_type;
                hdr[9]  = it.cmd_set;
                hdr[10] = it.cmd_id;
                run_crc = CRC16_SEED;
                for (int i = 0; i < HDR_LEN; i++) emit_byte(hdr[i]);
                if (it.payload_len == '0) begin
                    close_frame();
                end else begin
                    bytes_due = it.payload_len;
                    in_frame  = 1'b1;
                end
            end
        end else if (!in_frame) begin
            push_beat(8'h00, 1'b0, ST_SEQ_ERR);
        end else begin
            emit_byte(it.data_byte);
            bytes_due = bytes_due - LEN_W'(1);
            if (bytes_due == '0) close_frame();
        end
    endfunction

    // Stimulus builders; fields the item kind does not use are left random.
    function automatic t_in_item random_item();
        logic [95:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic void add_start(input logic [7:0] snd, input logic [7:0] rcv,
                                      input logic [15:0] seq, input logic [7:0] typ,
                                      input logic [7:0] grp, input logic [7:0] id,
                                      input logic [LEN_W-1:0] len);
        t_in_item it;
        it             = random_item();
        it.cmd         = CMD_START;
        it.sender      = snd;
        it.receiver    = rcv;
        it.seq_num     = seq;
        it.cmd_type    = typ;
        it.cmd_set     = grp;
        it.cmd_id      = id;
        it.payload_len = len;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void add_payload(input logic [7:0] d);
        t_in_item it;
        it           = random_item();
        it.cmd       = CMD_PAYLOAD;
        it.data_byte = d;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void add_rand_start(input logic [LEN_W-1:0] len);
        add_start(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), len);
    endfunction

    function automatic void add_frame(input logic [LEN_W-1:0] len);
        add_rand_start(len);
        for (int i = 0; i < len; i++) add_payload(8'($urandom));
    endfunction

    // Mostly short payloads, now and then a longer one.
    function automatic logic [LEN_W-1:0] rand_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60) return LEN_W'($urandom_range(0, 4));
        if (p < 92) return LEN_W'($urandom_range(5, 24));
        return LEN_W'($urandom_range(25, 80));
    endfunction

    // Sender: offers the next pending item at the falling edge, with random gaps.
    always @(negedge clk) begin
        t_in_item nxt;
        logic     v;
        v   = item_if.valid;
        nxt = item_if.payload;
        if (!rst_n) begin
            v = 1'b0;
        end else if (!item_if.valid || item_taken) begin
            v = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_items.size() != 0) begin
                if (!src_steady && pending_items.size() >= 40 &&
                    $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 14) - 1;
                end else begin
                    nxt = pending_items[0];
                    pending_items.delete(0);
                    v   = 1'b1;
                end
            end
        end
        src_tick++;
        if (src_tick % 128 == 0) src_steady = ($urandom_range(0, 3) == 0);
        item_if.valid   <= v;
        item_if.payload <= nxt;
    end

    // Receiver: random stalls, plus one long hold-off that backs the encoder up.
    always @(negedge clk) begin
        logic r;
        r = 1'b1;
        if (!rst_n) begin
            r = 1'b0;
        end else if (stall_left > 0) begin
            r = 1'b0;
            stall_left--;
        end else if (!hold_done && beats_seen >= 200) begin
            hold_done  = 1'b1;
            stall_left = 299;
            r = 1'b0;
        end else if (snk_gap > 0) begin
            r = 1'b0;
            snk_gap--;
        end else if (!snk_steady && pending_items.size() >= 40 &&
                     $urandom_range(0, 4) == 0) begin
            snk_gap = $urandom_range(1, 14) - 1;
            r = 1'b0;
        end
        snk_tick++;
        if (snk_tick % 128 == 0) snk_steady = ($urandom_range(0, 3) == 0);
        beat_if.ready <= r;
    end

    // Monitor: predict on every accepted item, check every accepted beat.
    always @(posedge clk) begin
        t_beat got;
        t_beat want;
        if (rst_n) begin
            if (item_if.valid && item_if.ready) encode_item(item_if.payload);
            if (beat_if.valid && beat_if.ready) begin
                got = beat_if.payload;
                beats_seen++;
                if (wire_bytes_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %02h last %0b status %0d",
                             $time, got.out_byte, got.last, got.status);
                    mismatches++;
                end else begin
                    want = wire_bytes_q[0];
                    wire_bytes_q.delete(0);
                    if (got.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want.out_byte, got.out_byte);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                end
            end
        end
        item_taken <= rst_n && item_if.valid && item_if.ready;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned pick;
        int unsigned len;

        // Directed part: stray payload, empty frames, length limits, out-of-order items.
        add_payload(8'hFF);
        add_start(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd0);
        add_start(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd0);
        add_rand_start(10'h3FF);
        add_rand_start(LEN_W'(MAX_PAYLOAD + 1));
        add_rand_start(10'd1);
        add_payload(8'h00);
        add_rand_start(10'd3);
        add_rand_start(10'h3FF);
        add_payload(8'hFF);
        add_rand_start(10'd0);
        add_payload(8'h00);
        add_payload(8'h5A);
        add_payload(8'h00);
        add_rand_start(10'd2);
        add_payload(8'($urandom));
        add_payload(8'($urandom));

        // Random part: mostly well-formed frames, the rest noise and broken frames.
        while (pending_items.size() < 260) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                add_frame(rand_len());
            end else if (pick < 86) begin
                add_payload(8'($urandom));
            end else if (pick < 92) begin
                add_rand_start(LEN_W'($urandom_range(MAX_PAYLOAD + 1, 1023)));
            end else if (pick < 96) begin
                // A start that barges into an open frame.
                len = $urandom_range(1, 6);
                add_rand_start(LEN_W'(len));
                for (int i = 0; i < len; i++) begin
                    if (i == len / 2) add_rand_start(rand_len());
                    add_payload(8'($urandom));
                end
            end else begin
                // A frame cut short; what follows runs into it.
                len = $urandom_range(2, 8);
                add_rand_start(LEN_W'(len));
                for (int i = 0; i < len - 1; i++) add_payload(8'($urandom));
            end
        end

        // A maximum-length frame opened last, so the high length bits go on the wire.
        add_rand_start(MAX_PAYLOAD);
        for (int i = 0; i < 4; i++) add_payload(8'($urandom));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_if.valid) @(posedge clk);
        while (wire_bytes_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
